@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
package bpa_pkg;
  typedef struct packed {
    logic       pool_is_user;
    logic [6:0] page_count;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic        last;
  } bpa_out_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_VIRT = 2'd1;
  localparam logic [1:0] ST_NO_PHYS = 2'd2;
  localparam logic [1:0] ST_USER    = 2'd3;

  localparam logic [2:0] REG_KERNEL_PAGES = 3'd0;
  localparam logic [2:0] REG_USER_PAGES   = 3'd1;
  localparam logic [2:0] REG_KERNEL_PHYS  = 3'd2;
  localparam logic [2:0] REG_USER_PHYS    = 3'd3;
  localparam logic [2:0] REG_VIRT_BASE    = 3'd4;

  localparam int PAGE_SHIFT = 12;
endpackage

@@ rtl/bpa_bitmap.sv @@
`timescale 1ns / 1ps
module bpa_bitmap import bpa_pkg::*; #(
  parameter int WORDS = 512,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clearing
);
  logic [7:0] mem [WORDS];
  logic [AW:0] clr_ptr;

  assign clearing = !clr_ptr[AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (clearing) begin
      clr_ptr <= (clr_ptr[AW-1:0] == AW'(WORDS - 1)) ? {1'b1, {AW{1'b0}}} : clr_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr[AW-1:0]] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ rtl/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// Bitmap page allocator for a kernel heap.
// A request item on req carries a pool flag and a page count. Each kernel
// request yields one result item per granted page on rsp, with last set on
// the final one; a failure ends the request with a single status item.
// The virtual page map and the kernel frame map are byte-wide memories with
// registered reads. The virtual search visits each byte of the pool with a
// read, a wait and a test of its bits one at a time. Marking the run reads,
// waits on and rewrites each touched byte. Each frame search restarts at the
// lowest byte and skips each full byte after a read and a test.
// Requests are handled one at a time. Registers should be written on cfg
// only while the block is idle; the block itself does not enforce this.
// After reset both maps are cleared, one byte a cycle, over all POOL_PAGES/8
// bytes; no request is taken during that sweep.
// When rsp is stalled, the result item is held and processing waits; the
// next result is produced only after the current one is taken.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int POOL_PAGES = 4096,
  parameter int MAX_RUN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  bpa_in_t     req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output bpa_out_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int WORDS = POOL_PAGES / 8;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW = AW + 3;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VREAD  = 4'd1;
  localparam logic [3:0] S_VWAIT  = 4'd2;
  localparam logic [3:0] S_VSCAN  = 4'd3;
  localparam logic [3:0] S_MREAD  = 4'd4;
  localparam logic [3:0] S_MWAIT  = 4'd5;
  localparam logic [3:0] S_MWRITE = 4'd6;
  localparam logic [3:0] S_FREAD  = 4'd7;
  localparam logic [3:0] S_FWAIT  = 4'd8;
  localparam logic [3:0] S_FTEST  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [12:0] kernel_pages, user_pages;
  logic [31:0] kernel_phys_base, user_phys_base, virt_base;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_pages     <= 13'd4096;
      user_pages       <= 13'd4096;
      kernel_phys_base <= 32'h0020_0000;
      user_phys_base   <= 32'h0120_0000;
      virt_base        <= 32'hC010_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL_PAGES: kernel_pages     <= cfg_data[12:0];
        REG_USER_PAGES:   user_pages       <= cfg_data[12:0];
        REG_KERNEL_PHYS:  kernel_phys_base <= cfg_data;
        REG_USER_PHYS:    user_phys_base   <= cfg_data;
        REG_VIRT_BASE:    virt_base        <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [IW:0] usable;
  logic [IW:0] usable_words;
  always_comb begin
    if ({19'd0, kernel_pages} > 32'(POOL_PAGES)) begin
      usable = (IW+1)'(POOL_PAGES);
    end else begin
      usable = (IW+1)'(kernel_pages);
    end
    usable = {usable[IW:3], 3'b000};
    usable_words = usable >> 3;
  end

  logic [3:0] state;
  logic [6:0] cnt, run, done;
  logic [IW:0] bit_ptr, start, vidx;
  logic [AW:0] word_ptr;
  logic [2:0] bsel;
  logic [7:0] byte_q;

  logic v_rd, v_wr, f_rd, f_wr, v_clr, f_clr;
  logic [AW-1:0] v_rd_a, v_wr_a, f_rd_a, f_wr_a;
  logic [7:0] v_rd_d, v_wr_d, f_rd_d, f_wr_d;

  bpa_bitmap #(.WORDS(WORDS), .AW(AW)) u_vmap (
    .clk, .rst, .rd_en(v_rd), .rd_addr(v_rd_a), .rd_data(v_rd_d),
    .wr_en(v_wr), .wr_addr(v_wr_a), .wr_data(v_wr_d), .clearing(v_clr));
  bpa_bitmap #(.WORDS(WORDS), .AW(AW)) u_fmap (
    .clk, .rst, .rd_en(f_rd), .rd_addr(f_rd_a), .rd_data(f_rd_d),
    .wr_en(f_wr), .wr_addr(f_wr_a), .wr_data(f_wr_d), .clearing(f_clr));

  logic [2:0] free_bit;
  logic       has_free;
  always_comb begin
    free_bit = 3'd0;
    has_free = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      if (!f_rd_d[b]) begin
        free_bit = 3'(b);
        has_free = 1'b1;
      end
    end
  end

  logic [7:0] mark_mask;
  logic [IW:0] run_end;
  assign run_end = start + (IW+1)'(cnt);
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mark_mask[b] = ({vidx[IW:3], 3'(b)} >= start) && ({vidx[IW:3], 3'(b)} < run_end);
    end
  end

  assign req_stall = (state != S_IDLE) || rsp_valid || v_clr || f_clr;

  assign v_rd   = (state == S_VREAD) || (state == S_MREAD);
  assign v_rd_a = (state == S_VREAD) ? word_ptr[AW-1:0] : vidx[IW-1:3];
  assign v_wr   = (state == S_MWRITE);
  assign v_wr_a = vidx[IW-1:3];
  assign v_wr_d = byte_q | mark_mask;
  assign f_rd   = (state == S_FREAD);
  assign f_rd_a = word_ptr[AW-1:0];
  assign f_wr   = (state == S_FWAIT) && has_free;
  assign f_wr_a = word_ptr[AW-1:0];
  assign f_wr_d = f_rd_d | (8'd1 << free_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid && !req_stall) begin
            cnt <= req.page_count;
            run <= '0;
            done <= '0;
            word_ptr <= '0;
            bit_ptr <= '0;
            if (req.pool_is_user) begin
              rsp <= '{ST_USER, 32'd0, 32'd0, 1'b1};
              rsp_valid <= 1'b1;
            end else if (req.page_count == 7'd0 || 32'(req.page_count) > 32'(MAX_RUN)) begin
              rsp <= '{ST_NO_VIRT, 32'd0, 32'd0, 1'b1};
              rsp_valid <= 1'b1;
            end else begin
              state <= S_VREAD;
            end
          end
        end
        S_VREAD: begin
          if (word_ptr >= usable_words[AW:0]) begin
            rsp <= '{ST_NO_VIRT, 32'd0, 32'd0, 1'b1};
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_VWAIT;
          end
        end
        S_VWAIT: begin
          byte_q <= v_rd_d;
          bsel <= 3'd0;
          state <= S_VSCAN;
        end
        S_VSCAN: begin
          bit_ptr <= bit_ptr + 1'b1;
          bsel <= bsel + 1'b1;
          if (byte_q[bsel]) begin
            run <= '0;
          end else begin
            run <= run + 1'b1;
          end
          if (!byte_q[bsel] && run + 1'b1 == cnt) begin
            start <= bit_ptr + 1'b1 - (IW+1)'(cnt);
            vidx <= bit_ptr + 1'b1 - (IW+1)'(cnt);
            state <= S_MREAD;
          end else if (bsel == 3'd7) begin
            word_ptr <= word_ptr + 1'b1;
            state <= S_VREAD;
          end
        end
        S_MREAD: state <= S_MWAIT;
        S_MWAIT: begin
          byte_q <= v_rd_d;
          state <= S_MWRITE;
        end
        S_MWRITE: begin
          if ({vidx[IW:3], 3'b111} + 1'b1 >= run_end) begin
            word_ptr <= '0;
            vidx <= start;
            state <= S_FREAD;
          end else begin
            vidx <= {vidx[IW:3] + 1'b1, 3'b000};
            state <= S_MREAD;
          end
        end
        S_FREAD: begin
          if (word_ptr >= usable_words[AW:0]) begin
            rsp <= '{ST_NO_PHYS, 32'd0, 32'd0, 1'b1};
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: begin
          if (has_free) begin
            rsp.status <= ST_OK;
            rsp.virt_addr <= virt_base + (32'(vidx) << PAGE_SHIFT);
            rsp.phys_addr <= kernel_phys_base
                             + (32'({word_ptr[AW-1:0], free_bit}) << PAGE_SHIFT);
            rsp.last <= (done + 1'b1 == cnt);
            rsp_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            word_ptr <= word_ptr + 1'b1;
            state <= S_FREAD;
          end
        end
        S_OUT: begin
          if (rsp_valid && !rsp_stall) begin
            if (rsp.last) begin
              state <= S_IDLE;
            end else begin
              done <= done + 1'b1;
              vidx <= vidx + 1'b1;
              word_ptr <= '0;
              state <= S_FREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^{user_pages, user_phys_base};
endmodule

@@ rtl/bpa_checker.sv @@
`timescale 1ns / 1ps
module bpa_props import bpa_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input bpa_out_t rsp
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last)
    else $error("failure item without last");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.virt_addr == 32'd0 && rsp.phys_addr == 32'd0)
    else $error("failure item carries an address");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a result waits");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken before the first was handled");
endmodule

bind bitmap_page_allocator bpa_props u_bpa_props (
  .clk, .rst, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp);

@@ verif/bpa_checker.sv @@
`timescale 1ns / 1ps
module bpa_checker import bpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  bpa_in_t     req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  bpa_out_t    rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  localparam int POOL = 4096;
  localparam int RUN_MAX = 64;

  bit          virt_map [POOL];
  bit          frame_map [POOL];
  logic [12:0] kernel_pages;
  logic [12:0] user_pages;
  logic [31:0] kernel_phys;
  logic [31:0] user_phys;
  logic [31:0] virt_base;
  bpa_out_t    grants_q[$];

  function automatic void push_result(logic [1:0] st, logic [31:0] va, logic [31:0] pa,
                                      logic lst);
    bpa_out_t e;
    e.status = st;
    e.virt_addr = va;
    e.phys_addr = pa;
    e.last = lst;
    grants_q.push_back(e);
  endfunction

  task automatic allocate_pages(input bpa_in_t r);
    int n;
    int cnt;
    int run;
    int start;
    int frame;
    bit found;
    n = (kernel_pages > POOL) ? POOL : int'(kernel_pages);
    n = n & ~7;
    cnt = int'(r.page_count);
    if (r.pool_is_user) begin
      push_result(ST_USER, '0, '0, 1'b1);
      return;
    end
    found = 0;
    run = 0;
    start = 0;
    if (cnt != 0 && cnt <= RUN_MAX) begin
      for (int i = 0; i < n && !found; i++) begin
        if (virt_map[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == cnt) begin
            found = 1;
            start = i + 1 - cnt;
          end
        end
      end
    end
    if (!found) begin
      push_result(ST_NO_VIRT, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < cnt; i++) virt_map[start + i] = 1;
    for (int i = 0; i < cnt; i++) begin
      frame = -1;
      for (int f = 0; f < n && frame < 0; f++) begin
        if (!frame_map[f]) frame = f;
      end
      if (frame < 0) begin
        push_result(ST_NO_PHYS, '0, '0, 1'b1);
        return;
      end
      frame_map[frame] = 1;
      push_result(ST_OK, virt_base + (32'(start + i) << PAGE_SHIFT),
                  kernel_phys + (32'(frame) << PAGE_SHIFT), i + 1 == cnt);
    end
  endtask

  always @(posedge clk) begin
    bpa_out_t e;
    if (rst) begin
      for (int i = 0; i < POOL; i++) begin
        virt_map[i] = 0;
        frame_map[i] = 0;
      end
      kernel_pages = 13'd4096;
      user_pages = 13'd4096;
      kernel_phys = 32'h0020_0000;
      user_phys = 32'h0120_0000;
      virt_base = 32'hC010_0000;
      grants_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_PAGES: kernel_pages = cfg_data[12:0];
          REG_USER_PAGES: user_pages = cfg_data[12:0];
          REG_KERNEL_PHYS: kernel_phys = cfg_data;
          REG_USER_PHYS: user_phys = cfg_data;
          REG_VIRT_BASE: virt_base = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (grants_q.size() == 0) begin
          $error("unexpected result item: status %0d virt_addr %h phys_addr %h last %0d",
                 rsp.status, rsp.virt_addr, rsp.phys_addr, rsp.last);
          errors++;
        end else begin
          e = grants_q.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, rsp.status);
            errors++;
          end
          if (rsp.virt_addr !== e.virt_addr) begin
            $error("virt_addr: expected %h, actual %h", e.virt_addr, rsp.virt_addr);
            errors++;
          end
          if (rsp.phys_addr !== e.phys_addr) begin
            $error("phys_addr: expected %h, actual %h", e.phys_addr, rsp.phys_addr);
            errors++;
          end
          if (rsp.last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, rsp.last);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) allocate_pages(req);
    end
    pending = grants_q.size();
  end
endmodule

@@ verif/bitmap_page_allocator_test.sv @@
`timescale 1ns / 1ps
module bitmap_page_allocator_test;
  import bpa_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  bpa_in_t     req;
  logic        rsp_valid;
  logic        rsp_stall;
  bpa_out_t    rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          stall_pct;
  int          holds_asked;
  int          holds_served;
  int          idle_cycles;
  int          burst_left;

  bitmap_page_allocator u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bpa_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stall pattern, with a long hold-off when one is asked for.
  initial begin
    holds_served = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < holds_asked) begin
        holds_served++;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** bitmap_page_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic is_user, input int cnt);
    bpa_in_t item;
    item.pool_is_user = is_user;
    item.page_count = cnt[6:0];
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      req_valid <= 1'b0;
      if (stall_pct != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
      else @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) send_item(1'b1, $urandom_range(0, 127));
    else if (pick < 10) send_item(1'b0, $urandom_range(0, 1) ? 0 : $urandom_range(65, 127));
    else if (pick < 75) send_item(1'b0, $urandom_range(1, 16));
    else send_item(1'b0, $urandom_range(17, 64));
  endtask

  task automatic run_phase(input int kpages, input logic [31:0] kbase, input logic [31:0] vbase,
                           input int nitems, input int pct, input bit hold);
    write_reg(REG_KERNEL_PAGES, kpages);
    write_reg(REG_USER_PAGES, $urandom_range(0, 1) ? 32'd0 : 32'd4096);
    write_reg(REG_KERNEL_PHYS, kbase);
    write_reg(REG_USER_PHYS, $urandom);
    write_reg(REG_VIRT_BASE, vbase);
    stall_pct = pct;
    if (hold) holds_asked++;
    for (int i = 0; i < nitems; i++) send_random();
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_KERNEL_PAGES;
    cfg_data <= '0;
    stall_pct = 0;
    holds_asked = 0;
    idle_cycles = 0;
    burst_left = 4;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: count extremes, oversized and zero counts, user pool.
    send_item(1'b0, 1);
    send_item(1'b0, 64);
    send_item(1'b0, 0);
    send_item(1'b0, 65);
    send_item(1'b0, 127);
    send_item(1'b1, 0);
    send_item(1'b1, 127);
    send_item(1'b1, 1);
    send_item(1'b0, 63);
    send_item(1'b0, 2);
    send_item(1'b0, 32);
    wait_idle();

    // Empty pool, then a full pool with base addresses at the top of the 32-bit range.
    write_reg(REG_KERNEL_PAGES, 0);
    send_item(1'b0, 1);
    wait_idle();
    write_reg(REG_KERNEL_PAGES, 4096);
    write_reg(REG_KERNEL_PHYS, 32'hFFFF_FFFF);
    write_reg(REG_VIRT_BASE, 32'hFFFF_F000);
    send_item(1'b0, 3);
    send_item(1'b0, 64);
    wait_idle();

    run_phase(0, 32'h0, 32'h0, 30, 30, 1'b0);
    run_phase(13, 32'hFFFF_F000, 32'hFFFF_FFFF, 30, 0, 1'b0);
    run_phase(300, $urandom, $urandom, 50, 60, 1'b1);
    run_phase(1000, 32'h0020_0000, 32'hC010_0000, 50, 20, 1'b0);
    run_phase(4095, $urandom, $urandom, 40, 40, 1'b1);
    run_phase(4096, 32'hFFFF_FFFF, 32'h0, 40, 10, 1'b0);
    run_phase(4096, $urandom, $urandom, 30, 0, 1'b0);

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("** bitmap_page_allocator: PASSED **");
    end else begin
      $display("** bitmap_page_allocator: FAILED **");
    end
    $finish;
  end
endmodule
